@@ hw/rtl/sis_pkg.sv @@
package sis_pkg;

	// Field widths of the request and response payloads
	localparam int VALUE_W = 16;
	localparam int POS_W   = 6;
	localparam int MCNT_W  = 7;

	// Request modes
	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PROBE,
		ST_SHIFT,
		ST_INSERT,
		ST_RESULT
	} st_t;

endpackage

@@ hw/rtl/sis_req_if.sv @@
interface sis_req_if import sis_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               mode;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);

endinterface

@@ hw/rtl/sis_rsp_if.sv @@
interface sis_rsp_if import sis_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              found;
	logic [POS_W-1:0]  position;
	logic [MCNT_W-1:0] member_count;
	logic              full_refused;

	modport source (output valid, output found, output position, output member_count,
		output full_refused, input ready);
	modport sink   (input valid, input found, input position, input member_count,
		input full_refused, output ready);

endinterface

@@ hw/rtl/sis_store.sv @@
module sis_store import sis_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [VALUE_W-1:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [VALUE_W-1:0]       rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/sorted_integer_set.sv @@
// Channel  Dir  Payload                                          Accepted when
// req      in   mode, value                                      req.valid & req.ready
// rsp      out  found, position, member_count, full_refused      rsp.valid & rsp.ready
//
// One request at a time: the request is accepted, then each search probe passes through
// the search and probe states (up to ceil(log2(count+1)) probes, paced by the registered
// read of the store), the search is closed, then for an add of a new value the entries
// from position upward shift up (one entry a cycle through the store's single write port),
// the value is inserted and the result is issued.
// arst_n empties the set; store contents are not cleared.
// A finished response waits in an output register; the next request is taken meanwhile.
module sorted_integer_set import sis_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sis_req_if.sink   req,
	sis_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	st_t st_q, st_d;

	logic               mode_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   lo_q, hi_q, mid_q, j_q, count_q;
	logic               hit_q, placed_q, refused_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_addr_q;

	logic               out_valid_q;
	logic               out_found_q, out_refused_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [MCNT_W-1:0]  out_cnt_q;

	logic [CNT_W-1:0]   mid_c, jm1_c;
	logic               search_done, out_free, can_add;
	logic [CNT_W+POS_W-1:0]  pos_ext;
	logic [CNT_W+MCNT_W-1:0] cnt_ext;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;

	sis_store #(.DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Derive search midpoint, shift source and result fields
	assign mid_c       = lo_q + ((hi_q - lo_q) >> 1);
	assign jm1_c       = j_q - CNT_ONE;
	assign search_done = !(lo_q < hi_q);
	assign out_free    = !out_valid_q || rsp.ready;
	assign can_add     = (mode_q == MODE_ADD) && (count_q != CAP_CNT);
	assign pos_ext     = {{POS_W{1'b0}}, lo_q};
	assign cnt_ext     = {{MCNT_W{1'b0}}, count_q};

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (req.valid) st_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (!search_done) st_d = ST_PROBE;
				else if (!hit_q && can_add) st_d = ST_SHIFT;
				else st_d = ST_RESULT;
			end
			ST_PROBE: st_d = ST_SEARCH;
			ST_SHIFT: begin
				if (j_q == lo_q) st_d = ST_INSERT;
			end
			ST_INSERT: st_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Drive handshake and store ports
	always_comb begin
		req.ready = 1'b0;
		mem_raddr = mid_c[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = pend_addr_q;
		mem_wdata = mem_rdata;
		case (st_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SHIFT: begin
				mem_raddr = jm1_c[IDX_W-1:0];
				mem_we    = pend_q;
			end
			ST_INSERT: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[IDX_W-1:0];
				mem_wdata = value_q;
			end
			default: ;
		endcase
	end

	// Advance the sequencer and its working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q  <= req.mode;
						value_q <= req.value;
						lo_q    <= '0;
						hi_q    <= count_q;
						hit_q   <= 1'b0;
					end
				end
				ST_SEARCH: begin
					mid_q     <= mid_c;
					j_q       <= count_q;
					pend_q    <= 1'b0;
					placed_q  <= hit_q || can_add;
					refused_q <= !hit_q && (mode_q == MODE_ADD) && (count_q == CAP_CNT);
				end
				ST_PROBE: begin
					if (mem_rdata < value_q) begin
						lo_q <= mid_q + CNT_ONE;
					end else begin
						hi_q  <= mid_q;
						hit_q <= (mem_rdata == value_q);
					end
				end
				ST_SHIFT: begin
					if (j_q != lo_q) begin
						j_q         <= jm1_c;
						pend_q      <= 1'b1;
						pend_addr_q <= j_q[IDX_W-1:0];
					end else begin
						pend_q <= 1'b0;
					end
				end
				ST_INSERT: count_q <= count_q + CNT_ONE;
				default: ;
			endcase
		end
	end

	// Hold the response until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RESULT && out_free) begin
			out_found_q   <= hit_q;
			out_refused_q <= refused_q;
			out_pos_q     <= placed_q ? pos_ext[POS_W-1:0] : '0;
			out_cnt_q     <= cnt_ext[MCNT_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.position     = out_pos_q;
	assign rsp.member_count = out_cnt_q;
	assign rsp.full_refused = out_refused_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("member count exceeds capacity");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SEARCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SHIFT && pend_q && j_q != lo_q) |-> (mem_waddr != mem_raddr))
		else $error("shift writes the entry being read");

	a_count_only_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_INSERT) |=> $stable(count_q))
		else $error("member count changed outside insert");

	a_refuse_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.full_refused) |-> (count_q == CAP_CNT))
		else $error("add refused while store not full");
`endif

endmodule
